FILE: design/bae_pkg.sv
// shared constants, types and codes for the binary arithmetic encoder
`timescale 1ns / 1ps

package bae_pkg;

	localparam int PROB_BITS  = 16;
	localparam int PROB_IN_W  = 17;
	localparam int P_W        = PROB_BITS + 1;
	localparam int CMP_W      = (PROB_IN_W > P_W) ? PROB_IN_W : P_W;
	localparam int RANGE_W    = 32;
	localparam int LOW_W      = RANGE_W + 1;
	localparam int PROD_W     = RANGE_W + P_W;
	localparam int BITS_W     = 32;
	localparam int BYTES_W    = 30;
	localparam int FLUSH_BITS = 4;
	localparam int FCNT_W     = $clog2(FLUSH_BITS);

	localparam logic [RANGE_W-1:0] RANGE_INIT   = 32'hFFFF_FFFF;
	localparam logic [RANGE_W-1:0] RENORM_LIMIT = 32'h00FF_FFFF;
	localparam logic [BITS_W-1:0]  BITS_MAX     = 32'hFFFF_FFFF;
	localparam logic [P_W-1:0]     PROB_UNITY   = P_W'(1) << PROB_BITS;

	typedef enum logic [1:0] {
		FUNC_ENCODE  = 2'd0,
		FUNC_FINISH  = 2'd1,
		FUNC_RESTART = 2'd2,
		FUNC_NONE    = 2'd3
	} func_t;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_MUL   = 5'b00010,
		ST_UPD   = 5'b00100,
		ST_SHIFT = 5'b01000,
		ST_FLUSH = 5'b10000
	} state_t;

	// one step of the shared shift unit
	typedef struct packed {
		logic               out_bit;
		logic [LOW_W-1:0]   low_nx;
		logic [RANGE_W-1:0] range_nx;
		logic [BITS_W-1:0]  bits_nx;
		logic [BYTES_W-1:0] byte_count;
		logic               renorm_done;
	} shift_res_t;

endpackage

FILE: design/binary_arithmetic_encoder_core.sv
// Binary arithmetic encoder with a 32-bit range, one coded bit per result word.
// Input channel (in_valid / in_stall): func, bit_value, one_prob. func encode codes
// one symbol with probability one_prob of a one (Q16, values above 1.0 saturate),
// finish flushes four bits, restart returns the coder to its reset state, code 3
// is ignored. An input word is taken only while the sequencer is idle.
// Output channel (out_valid / out_stall): out_bit, last, byte_count. Every emitted
// stream bit is one word; last marks the final bit of the input word that caused it,
// byte_count is the running byte total, saturating.
// Sequence: an encode passes the 32x17 multiplier register and then the range update,
// then shifts out one renormalization bit per cycle through the shared shift unit while
// the output register is free (0 to 24 bits, usually a few).
// Finish emits four flush bits through the shift unit; restart and code 3 act on acceptance.
// A held output word stalls the shift unit: one result register sits between the
// shifter and the port, so a stall on out_stall holds the sequencer in place.
// Reset (arst_n low) clears low and the bit counter, sets range to all ones and
// drops any pending output word.
`timescale 1ns / 1ps

module binary_arithmetic_encoder_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    func,
	input  logic                          bit_value,
	input  logic [bae_pkg::PROB_IN_W-1:0] one_prob,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          out_bit,
	output logic                          last,
	output logic [bae_pkg::BYTES_W-1:0]   byte_count
);
	import bae_pkg::*;

	state_t             state_q;
	logic [LOW_W-1:0]   low_q;
	logic [RANGE_W-1:0] range_q;
	logic [BITS_W-1:0]  bits_q;
	logic               bit_q;
	logic [P_W-1:0]     p_q;
	logic [FCNT_W-1:0]  flush_cnt_q;
	logic               out_valid_q;
	logic               out_bit_q;
	logic               last_q;
	logic [BYTES_W-1:0] byte_count_q;

	logic               in_take;
	logic               out_free;
	logic               emit;
	logic [CMP_W-1:0]   prob_ext;
	logic [P_W-1:0]     prob_sat;
	logic [RANGE_W-1:0] one_part;
	logic [RANGE_W-1:0] zero_part;
	logic [RANGE_W-1:0] range_upd;
	logic               flush_last;
	shift_res_t         sh;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_take   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign emit      = (state_q == ST_SHIFT || state_q == ST_FLUSH) && out_free;

	assign out_valid  = out_valid_q;
	assign out_bit    = out_bit_q;
	assign last       = last_q;
	assign byte_count = byte_count_q;

	always_comb begin
		prob_ext = CMP_W'(one_prob);
		prob_sat = (prob_ext > CMP_W'(PROB_UNITY)) ? PROB_UNITY : P_W'(prob_ext);
	end

	bae_split u_split (
		.clk       (clk),
		.load      (state_q == ST_MUL),
		.range_in  (range_q),
		.prob      (p_q),
		.one_part  (one_part),
		.zero_part (zero_part)
	);

	bae_shift u_shift (
		.low_in   (low_q),
		.range_in (range_q),
		.bits_in  (bits_q),
		.res      (sh)
	);

	assign range_upd  = bit_q ? one_part : zero_part;
	assign flush_last = (flush_cnt_q == FCNT_W'(FLUSH_BITS - 1));

	always_ff @(posedge clk) begin
		if (in_take) begin
			bit_q <= bit_value;
			p_q   <= prob_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			low_q       <= '0;
			range_q     <= RANGE_INIT;
			bits_q      <= '0;
			flush_cnt_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						case (func)
							FUNC_ENCODE:  state_q <= ST_MUL;
							FUNC_FINISH:  state_q <= ST_FLUSH;
							FUNC_RESTART: begin
								low_q   <= '0;
								range_q <= RANGE_INIT;
								bits_q  <= '0;
							end
							default: ;
						endcase
					end
				end
				ST_MUL: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					if (bit_q) begin
						low_q <= low_q + LOW_W'(zero_part);
					end
					range_q <= range_upd;
					state_q <= (range_upd <= RENORM_LIMIT) ? ST_SHIFT : ST_IDLE;
				end
				ST_SHIFT: begin
					if (out_free) begin
						low_q   <= sh.low_nx;
						range_q <= sh.range_nx;
						bits_q  <= sh.bits_nx;
						if (sh.renorm_done) begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_FLUSH: begin
					// range stays put during the flush
					if (out_free) begin
						low_q  <= sh.low_nx;
						bits_q <= sh.bits_nx;
						if (flush_last) begin
							flush_cnt_q <= '0;
							state_q     <= ST_IDLE;
						end else begin
							flush_cnt_q <= flush_cnt_q + FCNT_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_bit_q    <= sh.out_bit;
			last_q       <= (state_q == ST_SHIFT) ? sh.renorm_done : flush_last;
			byte_count_q <= sh.byte_count;
		end
	end

	// coder is renormalized whenever it waits for a word
	a_idle_norm: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> range_q > RENORM_LIMIT)
		else $error("range not renormalized while idle");

	// shifting only happens while the range is still small
	a_shift_small: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SHIFT |-> range_q <= RENORM_LIMIT)
		else $error("renormalization shift with large range");

	// flush counter rests at zero outside a flush
	a_fcnt_rest: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_FLUSH |-> flush_cnt_q == '0)
		else $error("flush counter not cleared");

	// a flush word always goes through the result register
	a_flush_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH && out_free) |=> out_valid_q)
		else $error("flush bit not presented");

endmodule

FILE: design/bae_split.sv
// registered range times probability product and clamped split of the range
`timescale 1ns / 1ps

module bae_split (
	input  logic                         clk,
	input  logic                         load,
	input  logic [bae_pkg::RANGE_W-1:0]  range_in,
	input  logic [bae_pkg::P_W-1:0]      prob,
	output logic [bae_pkg::RANGE_W-1:0]  one_part,
	output logic [bae_pkg::RANGE_W-1:0]  zero_part
);
	import bae_pkg::*;

	logic [PROD_W-1:0]  prod_s1;
	logic [RANGE_W-1:0] one_raw;
	logic [RANGE_W-1:0] zero_raw;

	always_ff @(posedge clk) begin
		if (load) begin
			prod_s1 <= PROD_W'(range_in) * PROD_W'(prob);
		end
	end

	always_comb begin
		one_raw   = prod_s1[PROB_BITS +: RANGE_W];
		zero_raw  = range_in - one_raw;
		one_part  = (one_raw == '0) ? RANGE_W'(1) : one_raw;
		zero_part = (zero_raw == '0) ? RANGE_W'(1) : zero_raw;
	end

endmodule

FILE: design/bae_shift.sv
// shared shift unit: emits bit 32 of low and shifts low and range by one
`timescale 1ns / 1ps

module bae_shift (
	input  logic [bae_pkg::LOW_W-1:0]   low_in,
	input  logic [bae_pkg::RANGE_W-1:0] range_in,
	input  logic [bae_pkg::BITS_W-1:0]  bits_in,
	output bae_pkg::shift_res_t         res
);
	import bae_pkg::*;

	logic [BITS_W:0] bytes_sum;

	always_comb begin
		res.out_bit     = low_in[LOW_W-1];
		res.low_nx      = {low_in[LOW_W-2:0], 1'b0};
		res.range_nx    = {range_in[RANGE_W-2:0], 1'b0};
		res.renorm_done = res.range_nx > RENORM_LIMIT;
		// bit counter saturates when full
		res.bits_nx     = (bits_in == BITS_MAX) ? bits_in : bits_in + BITS_W'(1);
		bytes_sum       = {1'b0, res.bits_nx} + (BITS_W + 1)'(7);
		res.byte_count  = bytes_sum[3 +: BYTES_W];
	end

endmodule

FILE: verif/binary_arithmetic_encoder_core_tb.sv
// self-checking testbench for the binary arithmetic encoder core
`timescale 1ns / 1ps

module binary_arithmetic_encoder_core_tb;
	import bae_pkg::*;

	localparam int CYCLE_LIMIT  = 300000;
	localparam int TAIL_CYCLES  = 40;
	localparam int RANDOM_ITEMS = 260;
	localparam int MAX_SHIFTS   = 24;

	typedef struct packed {
		logic               out_bit;
		logic               last;
		logic [BYTES_W-1:0] byte_count;
	} coded_word_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic [1:0]           func;
	logic                 bit_value;
	logic [PROB_IN_W-1:0] one_prob;
	logic                 out_valid;
	logic                 out_stall;
	logic                 out_bit;
	logic                 last;
	logic [BYTES_W-1:0]   byte_count;

	// predicted coder state
	logic [LOW_W-1:0]   coder_low;
	logic [RANGE_W-1:0] coder_range;
	logic [BITS_W-1:0]  coder_bits;

	coded_word_t expected_words[$];
	int          error_count;
	int          cycle_count;
	logic        calm;

	binary_arithmetic_encoder_core u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.func       (func),
		.bit_value  (bit_value),
		.one_prob   (one_prob),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_bit    (out_bit),
		.last       (last),
		.byte_count (byte_count)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	task automatic coder_clear();
		coder_low   = '0;
		coder_range = RANGE_INIT;
		coder_bits  = '0;
	endtask

	task automatic emit_coded_bit(input logic fin);
		coded_word_t w;
		logic [BITS_W:0] rounded;
		if (coder_bits != BITS_MAX)
			coder_bits = coder_bits + 1'b1;
		rounded      = {1'b0, coder_bits} + 33'd7;
		w.out_bit    = coder_low[LOW_W-1];
		w.last       = fin;
		w.byte_count = BYTES_W'(rounded >> 3);
		expected_words.push_back(w);
		coder_low = coder_low << 1;
	endtask

	// advance the predicted coder by one accepted word and queue its output bits
	task automatic predict_coded_bits(input func_t op, input logic sym,
			input logic [PROB_IN_W-1:0] p_in);
		logic [P_W-1:0]     p_sat;
		logic [PROD_W-1:0]  prod;
		logic [RANGE_W-1:0] one_part;
		logic [RANGE_W-1:0] zero_part;
		logic [RANGE_W-1:0] doubled;
		int n;
		case (op)
			FUNC_ENCODE: begin
				p_sat     = (p_in > PROB_IN_W'(PROB_UNITY)) ? PROB_UNITY : P_W'(p_in);
				prod      = PROD_W'(coder_range) * PROD_W'(p_sat);
				one_part  = RANGE_W'(prod >> PROB_BITS);
				zero_part = coder_range - one_part;
				if (one_part == '0)
					one_part = 1;
				if (zero_part == '0)
					zero_part = 1;
				if (sym) begin
					coder_low   = coder_low + LOW_W'(zero_part);
					coder_range = one_part;
				end else begin
					coder_range = zero_part;
				end
				n = 0;
				while (coder_range <= RENORM_LIMIT && n < MAX_SHIFTS) begin
					doubled = coder_range << 1;
					emit_coded_bit(doubled > RENORM_LIMIT);
					coder_range = doubled;
					n++;
				end
			end
			FUNC_FINISH: begin
				for (n = 0; n < FLUSH_BITS; n++)
					emit_coded_bit(n == FLUSH_BITS - 1);
			end
			FUNC_RESTART: begin
				coder_clear();
			end
			default: begin
			end
		endcase
	endtask

	// called at a falling edge; returns at the falling edge after acceptance, valid left high
	task automatic send_word(input func_t op, input logic sym, input logic [PROB_IN_W-1:0] p);
		while (!calm && $urandom_range(99) < 9) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid  = 1'b1;
		func      = op;
		bit_value = sym;
		one_prob  = p;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_coded_bits(op, sym, p);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid = 1'b0;
		while (expected_words.size() != 0)
			@(negedge clk);
	endtask

	function automatic logic [PROB_IN_W-1:0] pick_prob();
		int sel;
		sel = $urandom_range(99);
		if (sel < 20)
			return PROB_IN_W'($urandom_range(4095));
		else if (sel < 40)
			return PROB_IN_W'($urandom_range(65536, 61440));
		else if (sel < 75)
			return PROB_IN_W'($urandom_range(65536));
		else if (sel < 85)
			return PROB_IN_W'($urandom_range(131071, 65537));
		else begin
			case ($urandom_range(4))
				0: return PROB_IN_W'(0);
				1: return PROB_IN_W'(1);
				2: return PROB_IN_W'(65535);
				3: return PROB_IN_W'(65536);
				default: return PROB_IN_W'(131071);
			endcase
		end
	endfunction

	// symbol drawn either freely or following its own probability
	function automatic logic pick_symbol(input logic [PROB_IN_W-1:0] p);
		if ($urandom_range(1))
			return 1'($urandom_range(1));
		return ($urandom_range(65535) < p) ? 1'b1 : 1'b0;
	endfunction

	task automatic test_probability_extremes();
		send_word(FUNC_ENCODE, 1'b0, 17'd0);
		send_word(FUNC_ENCODE, 1'b1, 17'd0);
		send_word(FUNC_ENCODE, 1'b0, 17'd65536);
		send_word(FUNC_ENCODE, 1'b1, 17'd65536);
		send_word(FUNC_ENCODE, 1'b1, 17'd131071);
		send_word(FUNC_ENCODE, 1'b0, 17'd65537);
		send_word(FUNC_ENCODE, 1'b1, 17'd1);
		send_word(FUNC_ENCODE, 1'b0, 17'd65535);
		send_word(FUNC_ENCODE, 1'b1, 17'h0AAAA);
		send_word(FUNC_ENCODE, 1'b0, 17'h15555);
	endtask

	task automatic test_special_cases();
		// unused code must leave the coder untouched
		send_word(FUNC_NONE, 1'b1, 17'd131071);
		send_word(FUNC_FINISH, 1'b1, 17'd0);
		// coding carries on from the flushed state
		send_word(FUNC_ENCODE, 1'b1, 17'd32768);
		send_word(FUNC_ENCODE, 1'b0, 17'd1000);
		send_word(FUNC_RESTART, 1'b1, 17'd131071);
		// half split from full range: no renormalization
		send_word(FUNC_ENCODE, 1'b0, 17'd32768);
		send_word(FUNC_FINISH, 1'b0, 17'd65536);
		send_word(FUNC_FINISH, 1'b1, 17'd1);
		send_word(FUNC_RESTART, 1'b0, 17'd0);
		send_word(FUNC_FINISH, 1'b0, 17'd0);
	endtask

	task automatic test_pause_until_drained();
		logic [PROB_IN_W-1:0] p;
		for (int i = 0; i < 12; i++) begin
			p = pick_prob();
			send_word(FUNC_ENCODE, pick_symbol(p), p);
		end
		wait_drained();
		for (int i = 0; i < 8; i++) begin
			p = pick_prob();
			send_word(FUNC_ENCODE, pick_symbol(p), p);
		end
		send_word(FUNC_FINISH, 1'($urandom_range(1)), PROB_IN_W'($urandom_range(131071)));
	endtask

	task automatic test_random_stream();
		logic [PROB_IN_W-1:0] p;
		int sel;
		int sent;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			calm = (sent >= 100 && sent < 160);
			sel  = $urandom_range(99);
			p    = pick_prob();
			if (sel < 82) begin
				send_word(FUNC_ENCODE, pick_symbol(p), p);
				sent++;
			end else if (sel < 92) begin
				send_word(FUNC_FINISH, 1'($urandom_range(1)), p);
				sent++;
			end else if (sel < 96) begin
				send_word(FUNC_RESTART, 1'($urandom_range(1)), p);
				sent++;
			end else begin
				send_word(FUNC_NONE, 1'($urandom_range(1)), p);
			end
			if (sent == 220)
				wait_drained();
		end
		calm = 1'b0;
	endtask

	always @(negedge clk)
		out_stall <= calm ? 1'b0 : ($urandom_range(99) < 9);

	// compare every taken output word with the oldest predicted one
	always @(posedge clk) begin
		coded_word_t w;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_words.size() == 0) begin
				$display("%0t: unexpected word out_bit %0d last %0d byte_count %0d",
					$time, out_bit, last, byte_count);
				error_count++;
			end else begin
				w = expected_words.pop_front();
				if (out_bit !== w.out_bit) begin
					$display("%0t: out_bit expected %0d actual %0d", $time, w.out_bit, out_bit);
					error_count++;
				end
				if (last !== w.last) begin
					$display("%0t: last expected %0d actual %0d", $time, w.last, last);
					error_count++;
				end
				if (byte_count !== w.byte_count) begin
					$display("%0t: byte_count expected %0d actual %0d",
						$time, w.byte_count, byte_count);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		error_count = 0;
		cycle_count = 0;
		calm        = 1'b0;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		func        = FUNC_ENCODE;
		bit_value   = 1'b0;
		one_prob    = '0;
		out_stall   = 1'b0;
		coder_clear();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_probability_extremes();
		test_special_cases();
		test_pause_until_drained();
		test_random_stream();

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		error_count += expected_words.size();
		if (error_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

FILE: files.f
design/bae_pkg.sv
design/bae_split.sv
design/bae_shift.sv
design/binary_arithmetic_encoder_core.sv
verif/binary_arithmetic_encoder_core_tb.sv
